FILE: src/lbcg_pkg.sv
package lbcg_pkg;

    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_LONG_ON = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_OFF = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_ON = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_OFF = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_GAP = 3'd4;

    localparam logic [7:0] CODE_SOLID = 8'd7;
    localparam logic [7:0] CODE_MAX = 8'd8;

    localparam logic [8:0] PHASE_MAX = 9'd511;
    localparam logic [7:0] GAP_MAX = 8'd255;

    typedef struct packed {
        logic [8:0] phase;
        logic [7:0] gap;
        logic [2:0] done;
        logic       led;
    } t_blink;

    // Pattern table: number of long blinks per status code.
    function automatic logic [2:0] rom_long(input logic [3:0] code);
        logic [2:0] v;
        unique case (code)
            4'd1, 4'd2, 4'd3, 4'd4, 4'd6: v = 3'd1;
            4'd8:                         v = 3'd2;
            default:                      v = 3'd0;
        endcase
        return v;
    endfunction

    // Pattern table: number of short blinks per status code.
    function automatic logic [2:0] rom_short(input logic [3:0] code);
        logic [2:0] v;
        unique case (code)
            4'd1, 4'd8: v = 3'd1;
            4'd2:       v = 3'd2;
            4'd3:       v = 3'd3;
            4'd4, 4'd5: v = 3'd4;
            default:    v = 3'd0;
        endcase
        return v;
    endfunction

    function automatic logic [8:0] inc9(input logic [8:0] x);
        return (x == PHASE_MAX) ? x : x + 9'd1;
    endfunction

    function automatic logic [7:0] inc8(input logic [7:0] x);
        return (x == GAP_MAX) ? x : x + 8'd1;
    endfunction

    // One tick of a blink slot: lit for on ticks, then dark for off ticks
    // (an off time of zero wraps to 256 dark ticks).
    function automatic t_blink blink_step(input t_blink cur, input logic [7:0] on_t,
                                          input logic [7:0] off_t);
        t_blink     nxt;
        logic [7:0] last;
        nxt       = cur;
        last      = off_t - 8'd1;
        nxt.phase = inc9(cur.phase);
        if (cur.phase < {1'b0, on_t}) begin
            nxt.led = 1'b1;
        end else begin
            nxt.led = 1'b0;
            nxt.gap = inc8(cur.gap);
            if (cur.gap == last) begin
                nxt.gap   = 8'd0;
                nxt.phase = 9'd0;
                nxt.done  = cur.done + 3'd1;
            end
        end
        return nxt;
    endfunction

endpackage

FILE: src/led_blink_code_generator.sv
// The result of an accepted transaction is registered and reaches the master side in the next cycle.
// Throughput: one transaction per cycle; the blink state updates in a single pass.
// Input stalls only while a result waits and the master side does not take it.
// Reset (synchronous, active low) restores the default timing registers, code 0,
// the cycle boundary flag set, all counters cleared and the LED dark.
module led_blink_code_generator (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [lbcg_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [lbcg_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [7:0]                           s_axis_tdata,  // [7:0] status_code
    input  logic                                 s_axis_tuser,  // [0] action
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [7:0]                           m_axis_tdata   // [0] led_on, [7:1] zero
);

    logic [7:0] r_long_on, r_long_off, r_short_on, r_short_off, r_cycle_gap;

    logic [7:0] r_code, n_code;
    logic       r_cycle_fin, n_cycle_fin;
    logic [2:0] r_long_target, n_long_target;
    logic [2:0] r_short_target, n_short_target;
    logic [8:0] r_cycle_cnt, n_cycle_cnt;
    logic       r_led, n_led;
    lbcg_pkg::t_blink r_long, n_long, r_short, n_short;

    logic r_out_valid;
    logic r_out_led;
    logic in_accept;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_led};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_on   <= 8'd10;
            r_long_off  <= 8'd5;
            r_short_on  <= 8'd3;
            r_short_off <= 8'd3;
            r_cycle_gap <= 8'd20;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                lbcg_pkg::CFG_LONG_ON:   r_long_on   <= i_cfg_data;
                lbcg_pkg::CFG_LONG_OFF:  r_long_off  <= i_cfg_data;
                lbcg_pkg::CFG_SHORT_ON:  r_short_on  <= i_cfg_data;
                lbcg_pkg::CFG_SHORT_OFF: r_short_off <= i_cfg_data;
                lbcg_pkg::CFG_CYCLE_GAP: r_cycle_gap <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        logic       run;
        logic [8:0] c;
        n_code         = r_code;
        n_cycle_fin    = r_cycle_fin;
        n_long_target  = r_long_target;
        n_short_target = r_short_target;
        n_cycle_cnt    = r_cycle_cnt;
        n_led          = r_led;
        n_long         = r_long;
        n_short        = r_short;
        run            = 1'b1;
        c              = 9'd0;
        if (s_axis_tuser) begin
            n_code = s_axis_tdata;
        end else begin
            if (r_cycle_fin) begin
                n_cycle_fin = 1'b0;
                n_cycle_cnt = 9'd0;
                if (r_code == lbcg_pkg::CODE_SOLID) begin
                    // Solid on parks the block at the cycle boundary.
                    n_led       = 1'b1;
                    n_cycle_fin = 1'b1;
                    run         = 1'b0;
                end else if (r_code > lbcg_pkg::CODE_MAX) begin
                    // Boundary is consumed but the LED holds for this tick.
                    run = 1'b0;
                end else begin
                    n_long_target  = lbcg_pkg::rom_long(r_code[3:0]);
                    n_short_target = lbcg_pkg::rom_short(r_code[3:0]);
                    n_long.phase   = 9'd0;
                    n_long.done    = 3'd0;
                    n_short.phase  = 9'd0;
                    n_short.done   = 3'd0;
                end
            end
            if (run) begin
                if (n_long.done < n_long_target) begin
                    n_long = lbcg_pkg::blink_step(n_long, r_long_on, r_long_off);
                    n_led  = n_long.led;
                end else if (n_short.done < n_short_target) begin
                    n_short = lbcg_pkg::blink_step(n_short, r_short_on, r_short_off);
                    n_led   = n_short.led;
                end else begin
                    c           = n_cycle_cnt;
                    n_led       = 1'b0;
                    n_cycle_cnt = lbcg_pkg::inc9(c);
                    if (c >= {1'b0, r_cycle_gap}) begin
                        n_cycle_fin = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code         <= 8'd0;
            r_cycle_fin    <= 1'b1;
            r_long_target  <= 3'd0;
            r_short_target <= 3'd0;
            r_cycle_cnt    <= 9'd0;
            r_led          <= 1'b0;
            r_long         <= '0;
            r_short        <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (in_accept) begin
                r_code         <= n_code;
                r_cycle_fin    <= n_cycle_fin;
                r_long_target  <= n_long_target;
                r_short_target <= n_short_target;
                r_cycle_cnt    <= n_cycle_cnt;
                r_led          <= n_led;
                r_long         <= n_long;
                r_short        <= n_short;
                r_out_valid    <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_led <= n_led;
        end
    end

    // A blink run never counts past the number of blinks the pattern asked for.
    a_done_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_long.done <= r_long_target) && (r_short.done <= r_short_target))
        else $error("blink done count exceeds its target");

    // A code write leaves the LED level untouched.
    a_write_holds_led: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && s_axis_tuser) |=> (r_led == $past(r_led)))
        else $error("code write changed the LED level");

    // A tick at the boundary with the solid code lights the LED and stays at the boundary.
    a_solid_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && !s_axis_tuser && r_cycle_fin && (r_code == lbcg_pkg::CODE_SOLID))
        |=> (r_led && r_cycle_fin && r_out_led))
        else $error("solid code did not hold the LED lit");

    // The result register always mirrors the LED state after a transaction.
    a_out_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_out_valid && (r_out_led == r_led)))
        else $error("result register disagrees with LED state");

endmodule

FILE: tb/led_blink_code_generator_tb.sv
`timescale 1ns / 1ps

typedef enum bit {
    ACT_TICK  = 1'b0,
    ACT_WRITE = 1'b1
} t_action;

typedef struct packed {
    bit [8:0] phase;
    bit [7:0] gap;
    bit [2:0] done;
} t_blink_slot;

class blink_scoreboard;
    bit [7:0]    long_on, long_off, short_on, short_off, pause_len;
    bit [7:0]    code;
    bit          at_boundary;
    bit [2:0]    long_goal, short_goal;
    t_blink_slot long_slot, short_slot;
    bit [8:0]    pause_cnt;
    bit          led;
    bit          led_expect[$];
    int unsigned errors, n_ticks, n_writes, n_lit, n_solid, n_frozen;

    function new();
        long_on     = 8'd10;
        long_off    = 8'd5;
        short_on    = 8'd3;
        short_off   = 8'd3;
        pause_len   = 8'd20;
        at_boundary = 1'b1;
    endfunction

    function void set_timing(logic [lbcg_pkg::CFG_IDX_W-1:0] idx, bit [7:0] val);
        case (idx)
            lbcg_pkg::CFG_LONG_ON:   long_on   = val;
            lbcg_pkg::CFG_LONG_OFF:  long_off  = val;
            lbcg_pkg::CFG_SHORT_ON:  short_on  = val;
            lbcg_pkg::CFG_SHORT_OFF: short_off = val;
            lbcg_pkg::CFG_CYCLE_GAP: pause_len = val;
            default: ;
        endcase
    endfunction

    function bit [8:0] sat9(bit [8:0] x);
        return (x == 9'h1FF) ? x : x + 9'd1;
    endfunction

    function bit [7:0] sat8(bit [7:0] x);
        return (x == 8'hFF) ? x : x + 8'd1;
    endfunction

    // An off time of zero wraps the end marker to 255, which gives 256 dark ticks.
    function bit step_slot(inout t_blink_slot s, input bit [7:0] on_t, input bit [7:0] off_t);
        bit [8:0] p;
        bit [7:0] g;
        bit [7:0] last;
        p       = s.phase;
        s.phase = sat9(p);
        if (p < {1'b0, on_t}) return 1'b1;
        g     = s.gap;
        last  = off_t - 8'd1;
        s.gap = sat8(g);
        if (g == last) begin
            s.gap   = 8'd0;
            s.phase = 9'd0;
            s.done  = s.done + 3'd1;
        end
        return 1'b0;
    endfunction

    function void advance();
        bit [8:0] c;
        if (at_boundary) begin
            at_boundary = 1'b0;
            pause_cnt   = 9'd0;
            if (code == lbcg_pkg::CODE_SOLID) begin
                led         = 1'b1;
                at_boundary = 1'b1;
                n_solid++;
                return;
            end
            // A code beyond the pattern list consumes the boundary and keeps the old pattern.
            if (code > lbcg_pkg::CODE_MAX) begin
                n_frozen++;
                return;
            end
            case (code)
                8'd1:    begin long_goal = 3'd1; short_goal = 3'd1; end
                8'd2:    begin long_goal = 3'd1; short_goal = 3'd2; end
                8'd3:    begin long_goal = 3'd1; short_goal = 3'd3; end
                8'd4:    begin long_goal = 3'd1; short_goal = 3'd4; end
                8'd5:    begin long_goal = 3'd0; short_goal = 3'd4; end
                8'd6:    begin long_goal = 3'd1; short_goal = 3'd0; end
                8'd8:    begin long_goal = 3'd2; short_goal = 3'd1; end
                default: begin long_goal = 3'd0; short_goal = 3'd0; end
            endcase
            long_slot.phase  = 9'd0;
            short_slot.phase = 9'd0;
            long_slot.done   = 3'd0;
            short_slot.done  = 3'd0;
        end
        if (long_slot.done < long_goal) begin
            led = step_slot(long_slot, long_on, long_off);
        end else if (short_slot.done < short_goal) begin
            led = step_slot(short_slot, short_on, short_off);
        end else begin
            c         = pause_cnt;
            led       = 1'b0;
            pause_cnt = sat9(c);
            if (c >= {1'b0, pause_len}) at_boundary = 1'b1;
        end
    endfunction

    function void note_input(t_action act, bit [7:0] status);
        if (act == ACT_WRITE) begin
            code = status;
            n_writes++;
        end else begin
            advance();
            n_ticks++;
        end
        led_expect.push_back(led);
    endfunction

    function void check_result(logic [7:0] data);
        bit exp_led;
        if (led_expect.size() == 0) begin
            $error("led_on: result with no transaction waiting, expected none, actual %0d",
                   data[0]);
            errors++;
            return;
        end
        exp_led = led_expect.pop_front();
        if (data[0] !== exp_led) begin
            $error("led_on: expected %0d, actual %0d", exp_led, data[0]);
            errors++;
        end
        if (data[7:1] !== 7'd0) begin
            $error("tdata[7:1]: expected 0, actual 0x%0h", data[7:1]);
            errors++;
        end
        if (exp_led) n_lit++;
    endfunction

    function int pending();
        return led_expect.size();
    endfunction
endclass

module led_blink_code_generator_tb;

    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned PHASE_ITEMS   = 135;
    localparam int unsigned NUM_PHASES    = 8;
    localparam int unsigned SETTLE_CYCLES = 4;

    logic                            i_clk         = 1'b0;
    logic                            i_rst_n       = 1'b0;
    logic                            i_cfg_we      = 1'b0;
    logic [lbcg_pkg::CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [lbcg_pkg::CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [7:0]                      s_axis_tdata  = '0;
    logic                            s_axis_tuser  = 1'b0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [7:0]                      m_axis_tdata;

    int unsigned     tx_idle_pct = 0;
    int unsigned     rx_stall_pct = 0;
    int unsigned     cycles = 0;
    blink_scoreboard sb = new();

    led_blink_code_generator u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        m_axis_tready <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready === 1'b1)
            sb.note_input(t_action'(s_axis_tuser), s_axis_tdata);
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    task automatic send_item(input t_action act, input bit [7:0] status);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= status;
        @(posedge i_clk);
        while (s_axis_tready !== 1'b1) @(posedge i_clk);
    endtask

    // Stops the sender and lets every outstanding LED level come back.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_timing(input bit [7:0] lon, input bit [7:0] loff, input bit [7:0] son,
                               input bit [7:0] soff, input bit [7:0] gap);
        logic [lbcg_pkg::CFG_IDX_W-1:0] regs[5];
        bit [7:0]                       vals[5];
        regs = '{lbcg_pkg::CFG_LONG_ON, lbcg_pkg::CFG_LONG_OFF, lbcg_pkg::CFG_SHORT_ON,
                 lbcg_pkg::CFG_SHORT_OFF, lbcg_pkg::CFG_CYCLE_GAP};
        vals = '{lon, loff, son, soff, gap};
        for (int k = 0; k < 5; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= regs[k];
            i_cfg_data  <= vals[k];
            sb.set_timing(regs[k], vals[k]);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        bit [7:0] status;
        t_action  act;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: one-tick timings so every boundary case shows up quickly.
        load_timing(8'd1, 8'd1, 8'd1, 8'd1, 8'd0);
        send_item(ACT_TICK, 8'hFF);
        send_item(ACT_WRITE, 8'd7);
        send_item(ACT_TICK, 8'h00);
        send_item(ACT_TICK, 8'h55);
        send_item(ACT_WRITE, 8'd9);
        send_item(ACT_TICK, 8'hAA);
        send_item(ACT_TICK, 8'h00);
        send_item(ACT_WRITE, 8'd255);
        send_item(ACT_TICK, 8'hFF);
        send_item(ACT_TICK, 8'h00);
        send_item(ACT_WRITE, 8'd8);
        send_item(ACT_TICK, 8'h0F);
        send_item(ACT_WRITE, 8'd128);
        send_item(ACT_TICK, 8'hF0);
        send_item(ACT_TICK, 8'h00);
        send_item(ACT_TICK, 8'h00);
        send_item(ACT_TICK, 8'h00);
        send_item(ACT_TICK, 8'h00);
        send_item(ACT_TICK, 8'h00);
        send_item(ACT_TICK, 8'h00);
        send_item(ACT_WRITE, 8'd0);
        send_item(ACT_TICK, 8'h00);
        send_item(ACT_TICK, 8'h00);
        send_item(ACT_TICK, 8'h00);
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: load_timing(8'd1, 8'd1, 8'd1, 8'd1, 8'd0);
                1: load_timing(8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
                2: load_timing(8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
                3: load_timing(8'd10, 8'd5, 8'd3, 8'd3, 8'd20);
                default: load_timing(8'($urandom_range(0, 5)), 8'($urandom_range(1, 5)),
                                     8'($urandom_range(0, 5)), 8'($urandom_range(1, 5)),
                                     8'($urandom_range(0, 8)));
            endcase
            case (p % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 45; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 45; end
                default: begin tx_idle_pct = 23; rx_stall_pct = 23; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == PHASE_ITEMS / 2) drain();
                act = ($urandom_range(99) < 15) ? ACT_WRITE : ACT_TICK;
                if (act == ACT_WRITE && $urandom_range(99) < 70)
                    status = 8'($urandom_range(0, 9));
                else
                    status = 8'($urandom_range(0, 255));
                send_item(act, status);
            end
            drain();
        end

        $display("Covered %0d ticks and %0d code writes over %0d timing settings and 4 idle mixes.",
                 sb.n_ticks, sb.n_writes, NUM_PHASES + 1);
        $display("Solid-on boundaries: %0d, frozen boundaries: %0d, lit results: %0d.",
                 sb.n_solid, sb.n_frozen, sb.n_lit);
        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
